// ===== hw/rtl/tmp_pkg.sv =====
`timescale 1ns / 1ps

package tmp_pkg;

  localparam int unsigned LEN_W  = 24;
  localparam int unsigned REG_W  = 32;
  localparam int unsigned TIME_W = 48;

  localparam logic [REG_W-1:0]  MAX_VELOCITY_RST = 32'd144179200;
  localparam logic [REG_W-1:0]  ACCELERATION_RST = 32'd1526989;
  localparam logic [REG_W-1:0]  TICK_PERIOD_RST  = 32'd17179869;
  localparam logic [LEN_W-1:0]  TARGET_RST       = 24'd10;
  localparam logic [TIME_W-1:0] TIME_MAX         = '1;

  typedef enum logic [1:0] {
    REG_MAX_VELOCITY = 2'd0,
    REG_ACCELERATION = 2'd1,
    REG_TICK_PERIOD  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_END  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_CRUISE,
    SEG_DOWN,
    SEG_END
  } seg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LA,
    S_VV,
    S_T1,
    S_LV,
    S_Q,
    S_ROOT,
    S_TICK,
    S_MA,
    S_MB,
    S_MC,
    S_MD,
    S_ME,
    S_MF,
    S_MG,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] y;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic [71:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

// ===== hw/rtl/tmp_mul.sv =====
`timescale 1ns / 1ps

module tmp_mul import tmp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mul_req_t     req,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] xr;
  logic [63:0] yr;
  logic [2:0]  cnt;
  logic        busy;
  logic [63:0] pp;
  logic [1:0]  pp_sh;
  logic        pp_vld;
  logic [31:0] xpart;
  logic [31:0] ypart;
  logic [127:0] pp_ext;

  assign xpart = cnt[1] ? xr[63:32] : xr[31:0];
  assign ypart = cnt[0] ? yr[63:32] : yr[31:0];

  always_comb begin
    unique case (pp_sh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      2'd2:    pp_ext = {pp, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // One 32x32 partial product per cycle; each is registered and added on the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        xr     <= req.x;
        yr     <= req.y;
        prod   <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
        pp_vld <= 1'b0;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp     <= 64'(xpart * ypart);
          pp_sh  <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          pp_vld <= 1'b1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld) begin
          prod <= prod + pp_ext;
        end
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/tmp_divsqrt.sv =====
`timescale 1ns / 1ps

module tmp_divsqrt import tmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [71:0] quot
);

  logic [71:0] sh;
  logic [35:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        mode;
  logic [35:0] trial_rem;
  logic [35:0] trial_sub;

  // Division brings down one numerator bit a step; the root brings down two.
  always_comb begin
    if (mode) begin
      trial_rem = {rem[33:0], sh[71:70]};
      trial_sub = {2'b00, quot[31:0], 2'b01};
    end else begin
      trial_rem = {2'b00, rem[32:0], sh[71]};
      trial_sub = {4'd0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mode <= req.sqrt_mode;
        sh   <= req.sqrt_mode ? {req.num[63:0], 8'd0} : req.num;
        den  <= req.den;
        rem  <= '0;
        quot <= '0;
        cnt  <= req.sqrt_mode ? 7'd32 : 7'd72;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial_rem >= trial_sub) begin
          rem  <= trial_rem - trial_sub;
          quot <= {quot[70:0], 1'b1};
        end else begin
          rem  <= trial_rem;
          quot <= {quot[70:0], 1'b0};
        end
        sh  <= mode ? {sh[69:0], 2'b00} : {sh[70:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/trapezoid_move_profile.sv =====
`timescale 1ns / 1ps
// An advance item runs up to seven 64x64 products on one shared 32x32 multiplier; a start, or
// an advance while the status is idle, first adds two products and two 72-step divisions, or
// one 72-step division and, unless its quotient overflows, a 32-step square root. A stalled
// result holds the next result in its final state until the stalled one is taken.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (synchronous): registers return to their default values and the status is idle.
module trapezoid_move_profile import tmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // move_length[23:0]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // position[23:0], velocity[55:24], remaining[79:56]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic [REG_W-1:0]  max_velocity;
  logic [REG_W-1:0]  acceleration;
  logic [REG_W-1:0]  tick_period;
  state_t            state, state_next;
  seg_t              seg;
  status_t           status;
  status_t           out_status;
  logic              launched;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] ramp;
  logic [TIME_W-1:0] cruise;
  logic [LEN_W-1:0]  target;
  logic [LEN_W-1:0]  cur_pos;
  logic [63:0]       w;
  logic [63:0]       pos;
  logic [31:0]       vel;
  logic [31:0]       out_vel;
  logic [LEN_W-1:0]  out_rem;

  logic [REG_W-1:0]  a_eff;
  logic [REG_W-1:0]  v_eff;
  logic              in_acc;
  logic              out_free;
  logic              is_mul;
  logic              is_div;
  logic              unit_done;
  mul_req_t          mreq;
  div_req_t          dreq;
  logic              mdone;
  logic              ddone;
  logic [127:0]      mprod;
  logic [71:0]       dquot;
  logic [48:0]       t_sum;
  logic [TIME_W-1:0] t_new;
  logic [48:0]       t1p2;
  logic [49:0]       t_end;
  logic [48:0]       tau_w;
  logic [49:0]       rest_w;
  logic [TIME_W-1:0] t_cr;
  logic [TIME_W-1:0] lv;
  logic [TIME_W-1:0] t1_sat;
  logic              trap;
  logic [63:0]       dn;
  logic [LEN_W-1:0]  pos_clamp;

  function automatic logic [31:0] sat_speed(input logic [127:0] p);
    return (p[95:64] != 32'd0) ? 32'hFFFF_FFFF : p[63:32];
  endfunction

  assign a_eff    = (acceleration == '0) ? 32'd1 : acceleration;
  assign v_eff    = (max_velocity == '0) ? 32'd1 : max_velocity;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign t_sum  = {1'b0, elapsed} + {17'd0, tick_period};
  assign t_new  = t_sum[48] ? TIME_MAX : t_sum[47:0];
  assign t1p2   = {1'b0, ramp} + {1'b0, cruise};
  assign t_end  = {1'b0, t1p2} + {2'b00, ramp};
  assign tau_w  = {1'b0, elapsed} - t1p2;
  assign rest_w = t_end - {2'b00, elapsed};
  assign t_cr   = elapsed - ramp;
  assign t1_sat = (dquot[71:48] != '0) ? TIME_MAX : dquot[47:0];
  assign lv     = t1_sat;
  assign trap   = (w[55:48] != 8'd0) || ({w[47:0], 16'd0} >= mprod[63:0]);
  assign dn     = {1'b0, mprod[127:65]};
  assign pos_clamp = (pos > {40'd0, target}) ? target : pos[LEN_W-1:0];

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    unique case (state)
      S_LA, S_VV, S_MA, S_MB, S_MC, S_MD, S_ME, S_MF, S_MG: is_mul = 1'b1;
      S_T1, S_LV, S_Q, S_ROOT:                            is_div = 1'b1;
      default: ;
    endcase
  end

  assign unit_done = (is_mul && mdone) || (is_div && ddone);

  // Operand selection for the shared units.
  always_comb begin
    mreq.start = is_mul && !launched;
    mreq.x     = {32'd0, a_eff};
    mreq.y     = '0;
    unique case (state)
      S_LA: begin
        mreq.x = {40'd0, target};
        mreq.y = {32'd0, a_eff};
      end
      S_VV: begin
        mreq.x = {32'd0, v_eff};
        mreq.y = {32'd0, v_eff};
      end
      S_MA: mreq.y = {16'd0, (seg == SEG_RAMP) ? elapsed : ramp};
      S_MB: begin
        mreq.x = w;
        mreq.y = {16'd0, (seg == SEG_RAMP) ? elapsed : ramp};
      end
      S_MC: begin
        mreq.x = w;
        mreq.y = {16'd0, (seg == SEG_CRUISE) ? t_cr : cruise};
      end
      S_MD: begin
        mreq.x = w;
        mreq.y = {16'd0, tau_w[47:0]};
      end
      S_ME: mreq.y = {16'd0, tau_w[47:0]};
      S_MF: begin
        mreq.x = w;
        mreq.y = {16'd0, tau_w[47:0]};
      end
      S_MG: mreq.y = {14'd0, rest_w};
      default: ;
    endcase

    dreq.start     = is_div && !launched;
    dreq.sqrt_mode = (state == S_ROOT);
    dreq.num       = {target, 48'd0};
    dreq.den       = a_eff;
    unique case (state)
      S_T1:   dreq.num = {8'd0, v_eff, 32'd0};
      S_LV:   dreq.den = v_eff;
      S_ROOT: dreq.num = {8'd0, w};
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) begin
        state_next = (s_axis_tuser[0] || status == ST_IDLE) ? S_LA : S_TICK;
      end
      S_LA:   if (unit_done) state_next = S_VV;
      S_VV:   if (unit_done) state_next = trap ? S_T1 : S_Q;
      S_T1:   if (unit_done) state_next = S_LV;
      S_LV:   if (unit_done) state_next = S_TICK;
      S_Q:    if (unit_done) state_next = (dquot[71:64] != 8'd0) ? S_TICK : S_ROOT;
      S_ROOT: if (unit_done) state_next = S_TICK;
      S_TICK: begin
        if ({1'b0, t_new} <= {1'b0, ramp}) begin
          state_next = S_MA;
        end else if ({1'b0, t_new} <= t1p2) begin
          state_next = S_MA;
        end else if ({2'b00, t_new} < t_end) begin
          state_next = S_MA;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MA:   if (unit_done) state_next = S_MB;
      S_MB:   if (unit_done) state_next = (seg == SEG_RAMP) ? S_FIN : S_MC;
      S_MC:   if (unit_done) state_next = (seg == SEG_CRUISE) ? S_FIN : S_MD;
      S_MD:   if (unit_done) state_next = S_ME;
      S_ME:   if (unit_done) state_next = S_MF;
      S_MF:   if (unit_done) state_next = S_MG;
      S_MG:   if (unit_done) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity  <= MAX_VELOCITY_RST;
      acceleration  <= ACCELERATION_RST;
      tick_period   <= TICK_PERIOD_RST;
      status        <= ST_IDLE;
      elapsed       <= '0;
      ramp          <= '0;
      cruise        <= '0;
      target        <= TARGET_RST;
      cur_pos       <= '0;
      launched      <= 1'b0;
      seg           <= SEG_RAMP;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_VELOCITY: max_velocity <= cfg_data;
          REG_ACCELERATION: acceleration <= cfg_data;
          REG_TICK_PERIOD:  tick_period  <= cfg_data;
          default: ;
        endcase
      end

      if (mreq.start || dreq.start) begin
        launched <= 1'b1;
      end else if (unit_done) begin
        launched <= 1'b0;
      end

      if (m_axis_tvalid && m_axis_tready && !(state == S_FIN && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: if (in_acc) begin
          if (s_axis_tuser[0]) begin
            target <= s_axis_tdata;
          end
          if (s_axis_tuser[0] || status == ST_IDLE) begin
            elapsed <= '0;
            status  <= ST_BUSY;
          end
        end
        S_LA: if (unit_done) w <= mprod[63:0];
        S_T1: if (unit_done) ramp <= t1_sat;
        S_LV: if (unit_done) cruise <= (lv > ramp) ? lv - ramp : '0;
        S_Q: if (unit_done) begin
          w      <= dquot[63:0];
          ramp   <= TIME_MAX;
          cruise <= '0;
        end
        S_ROOT: if (unit_done) ramp <= {dquot[31:0], 16'd0};
        S_TICK: begin
          elapsed <= t_new;
          if ({1'b0, t_new} <= {1'b0, ramp}) begin
            seg <= SEG_RAMP;
          end else if ({1'b0, t_new} <= t1p2) begin
            seg <= SEG_CRUISE;
          end else if ({2'b00, t_new} < t_end) begin
            seg <= SEG_DOWN;
          end else begin
            seg    <= SEG_END;
            status <= ST_END;
            pos    <= {40'd0, target};
            vel    <= '0;
          end
        end
        S_MA: if (unit_done) begin
          w   <= mprod[79:16];
          vel <= sat_speed(mprod);
        end
        S_MB: if (unit_done) pos <= {1'b0, mprod[127:65]};
        S_MC, S_MD: if (unit_done) pos <= pos + mprod[127:64];
        S_ME: if (unit_done) w <= mprod[79:16];
        S_MF: if (unit_done) pos <= (pos > dn) ? pos - dn : '0;
        S_MG: if (unit_done) vel <= sat_speed(mprod);
        S_FIN: if (out_free) begin
          cur_pos       <= pos_clamp;
          out_rem       <= target - pos_clamp;
          out_vel       <= vel;
          out_status    <= status;
          m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  tmp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (mprod)
  );

  tmp_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  assign m_axis_tdata = {out_rem, out_vel, cur_pos};
  assign m_axis_tuser = out_status;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tmp_pkg::*;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_START   = 1'b1;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [23:0] len;
  } move_cmd_t;

  typedef struct packed {
    logic [23:0] pos;
    logic [31:0] vel;
    logic [23:0] rem;
    logic [1:0]  st;
  } sample_t;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [31:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  trapezoid_move_profile uut (.*);

  move_cmd_t pending_cmds[$];
  sample_t   expected_samples[$];
  logic      cmd_taken;
  logic      no_stall;
  int        mismatches;

  // Shadow registers and motion state.
  logic [31:0] vmax_r, acc_r, tick_r;
  logic [1:0]  mstat;
  logic [63:0] t_elapsed, t_ramp, t_cruise;
  logic [23:0] tgt_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] acc_used();
    return (acc_r == 0) ? 64'd1 : {32'd0, acc_r};
  endfunction

  function automatic logic [31:0] speed_at(input logic [63:0] d);
    logic [127:0] p;
    p = acc_used() * d;
    p = p >> 32;
    return (p > M32) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [63:0] swept(input logic [63:0] a, input logic [63:0] b,
                                        input logic halve);
    logic [127:0] p;
    logic [63:0] w;
    p = acc_used() * a;
    w = p[79:16];
    p = w * b;
    return halve ? (p[127:64] >> 1) : p[127:64];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] xin);
    logic [63:0] x, r, b;
    x = xin;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic plan_move();
    logic [63:0] a, v, la, ip, rm, q, t1, lv;
    a = acc_used();
    v = (vmax_r == 0) ? 64'd1 : {32'd0, vmax_r};
    la = {40'd0, tgt_len} * a;
    if ((la >> 48) != 0 || (la << 16) >= v * v) begin
      t1 = (v << 32) / a;
      if (t1 > M48) t1 = M48;
      ip = ({40'd0, tgt_len} << 16) / v;
      rm = ({40'd0, tgt_len} << 16) % v;
      lv = (ip >= 65536) ? M48 : ((ip << 32) | ((rm << 32) / v));
      t_ramp = t1;
      t_cruise = (lv > t1) ? lv - t1 : 0;
    end else begin
      ip = ({40'd0, tgt_len} << 16) / a;
      rm = ({40'd0, tgt_len} << 16) % a;
      q = (ip << 32) | ((rm << 32) / a);
      t_ramp = (ip >= 64'h1_0000_0000) ? M48 : (int_sqrt(q) << 16);
      t_cruise = 0;
    end
    t_elapsed = 0;
    mstat = ST_BUSY;
  endtask

  task automatic predict_sample(input move_cmd_t c);
    logic [63:0] t, t1, t2, pos, tau, up, dn;
    logic [31:0] vel;
    sample_t s;
    if (c.op == OP_START) begin
      tgt_len = c.len;
      plan_move();
    end else if (mstat == ST_IDLE) begin
      plan_move();
    end
    t = t_elapsed + tick_r;
    if (t > M48) t = M48;
    t_elapsed = t;
    t1 = t_ramp;
    t2 = t_cruise;
    if (t <= t1) begin
      vel = speed_at(t);
      pos = swept(t, t, 1'b1);
    end else if (t <= t1 + t2) begin
      vel = speed_at(t1);
      pos = swept(t1, t1, 1'b1) + swept(t1, t - t1, 1'b0);
    end else if (t < 2 * t1 + t2) begin
      tau = t - t1 - t2;
      up = swept(t1, t1, 1'b1) + swept(t1, t2, 1'b0) + swept(t1, tau, 1'b0);
      dn = swept(tau, tau, 1'b1);
      vel = speed_at(2 * t1 + t2 - t);
      pos = (up > dn) ? up - dn : 0;
    end else begin
      vel = 0;
      pos = {40'd0, tgt_len};
      mstat = ST_END;
    end
    if (pos > tgt_len) pos = {40'd0, tgt_len};
    s.pos = pos[23:0];
    s.vel = vel;
    s.rem = tgt_len - pos[23:0];
    s.st = mstat;
    expected_samples.push_back(s);
  endtask

  // Monitor: predicts on accepted commands, checks accepted samples.
  always @(posedge clk) begin
    sample_t e, a;
    if (rst) begin
      cmd_taken <= 1'b0;
      vmax_r = MAX_VELOCITY_RST;
      acc_r = ACCELERATION_RST;
      tick_r = TICK_PERIOD_RST;
      mstat = ST_IDLE;
      t_elapsed = 0;
      t_ramp = 0;
      t_cruise = 0;
      tgt_len = TARGET_RST;
    end else begin
      cmd_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_VELOCITY: vmax_r = cfg_data;
          REG_ACCELERATION: acc_r = cfg_data;
          REG_TICK_PERIOD:  tick_r = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_sample('{op: s_axis_tuser[0], len: s_axis_tdata});
      if (m_axis_tvalid && m_axis_tready) begin
        a = '{pos: m_axis_tdata[23:0], vel: m_axis_tdata[55:24], rem: m_axis_tdata[79:56],
              st: m_axis_tuser};
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample %h", a);
        end else begin
          e = expected_samples.pop_front();
          if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: expected pos %0d vel %0d rem %0d st %0d, got pos %0d vel %0d rem %0d st %0d",
                       e.pos, e.vel, e.rem, e.st, a.pos, a.vel, a.rem, a.st);
          end
        end
      end
    end
  end

  // Driver: holds an offered command until it is taken.
  always @(negedge clk) begin
    move_cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_stall || ($urandom_range(99) >= 36);
      if (s_axis_tvalid && !cmd_taken) begin
        // still waiting for acceptance
      end else if (pending_cmds.size() > 0 && (no_stall || $urandom_range(99) >= 36)) begin
        c = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.op;
        s_axis_tdata <= c.len;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic queue_cmd(input logic op, input logic [23:0] len);
    pending_cmds.push_back('{op: op, len: len});
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k;
    logic [31:0] v, a, t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_MAX_VELOCITY;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    no_stall = 1'b0;
    mismatches = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Advance while idle plans the held ten micrometre move.
    queue_cmd(OP_ADVANCE, 24'd0);
    queue_cmd(OP_ADVANCE, 24'hFFFFFF);
    queue_cmd(OP_START, 24'd0);
    queue_cmd(OP_ADVANCE, 24'd0);
    queue_cmd(OP_START, 24'hFFFFFF);
    for (k = 0; k < 4; k++) queue_cmd(OP_ADVANCE, 24'd0);
    queue_cmd(OP_START, 24'd1);
    queue_cmd(OP_ADVANCE, 24'd0);
    queue_cmd(OP_START, 24'd5000);
    for (k = 0; k < 5; k++) queue_cmd(OP_ADVANCE, 24'd0);
    drain();

    for (int ph = 1; ph < 10; ph++) begin
      case (ph)
        1: begin v = 0; a = 0; t = 0; end
        2: begin v = '1; a = '1; t = '1; end
        3: begin v = 1; a = 1; t = 1; end
        4: begin v = 32'd1 << 16; a = '1; t = '1; end
        default: begin
          v = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0800_0000);
          a = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
          t = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
        end
      endcase
      write_reg(REG_MAX_VELOCITY, v);
      write_reg(REG_ACCELERATION, a);
      write_reg(REG_TICK_PERIOD, t);
      no_stall = (ph == 6);
      for (k = 0; k < 75; k++) begin
        if ($urandom_range(11) == 0)
          queue_cmd(OP_START, ($urandom_range(3) == 0) ? 24'($urandom) :
                                                         24'($urandom_range(3000)));
        else
          queue_cmd(OP_ADVANCE, 24'($urandom));
      end
      drain();
    end

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
